// File: rtl/core/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants for the command frame receiver: frame
// characters, event and command codes, blink constants and robot/post table sizes.
// ----------------------------------------------------------------------------
package cfr_pkg;

	localparam int unsigned ROBOT_COUNT = 8;
	localparam int unsigned POST_COUNT  = 16;

	localparam int unsigned FRAME_LEN = 4;

	typedef logic [7:0] char_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_NULL    = 3'd1,
		EV_ROBOT   = 3'd2,
		EV_REQUEST = 3'd3,
		EV_OTHER   = 3'd4
	} event_t;

	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_LF    = 8'h0A;
	localparam char_t CH_N     = 8'h4E;
	localparam char_t CH_U     = 8'h55;
	localparam char_t CH_L     = 8'h4C;
	localparam char_t CH_R     = 8'h52;
	localparam char_t CH_P     = 8'h50;
	localparam char_t CH_E     = 8'h45;
	localparam char_t CH_D     = 8'h44;
	localparam char_t CH_A     = 8'h41;
	localparam char_t CH_LOW_A = 8'h61;
	localparam char_t CH_LOW_D = 8'h64;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CASE_BIT = 8'h20;

	localparam logic [15:0] BLINK_PERIOD_RESET = 16'd150;
	localparam logic [15:0] ELAPSED_MAX        = 16'hFFFF;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

endpackage

// File: rtl/core/command_frame_receiver_top.sv
// An accepted word is held in the input register, and its result in the
// result register.
// Throughput: one word per cycle, sustained while the output side keeps
// taking results; the input register takes one more word while a result waits.
// Reset: frame buffer emptied, blinking off, LED high, period back to 150 ms.
// ----------------------------------------------------------------------------
// command_frame_receiver_top
// Collects received bytes into four-character frames, decodes complete frames
// into robot updates, post requests, null or other events, and runs the LED blink from ms ticks.
// ----------------------------------------------------------------------------
module command_frame_receiver_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [7:0]         rx_byte,
	input  logic [7:0]         post_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         event_res,
	output logic [3:0]         robot_index,
	output logic [7:0]         robot_speed,
	output logic [7:0]         robot_status,
	output logic               clear_pickup,
	output logic               clear_delivery,
	output logic [7:0]         request_post,
	output logic signed [12:0] request_dest,
	output logic [1:0]         request_service,
	output logic               led_level,
	output logic               blink_active
);

	// Input register
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic [7:0] post_s1;

	// Block state
	logic [15:0]          blink_period_q;
	logic [2:0]           frame_count_q;
	cfr_pkg::char_t       frame_chars_q [cfr_pkg::FRAME_LEN];
	logic [3:0]           blink_remaining_q;
	logic [15:0]          blink_elapsed_q;
	logic                 led_phase_q;
	logic                 led_pin_q;

	// Result register
	logic                 out_valid_q;
	cfr_pkg::event_t      event_q;
	logic [3:0]           robot_index_q;
	logic [7:0]           robot_speed_q;
	logic [7:0]           robot_status_q;
	logic                 clear_pickup_q;
	logic                 clear_delivery_q;
	logic [7:0]           request_post_q;
	logic signed [12:0]   request_dest_q;
	logic [1:0]           request_service_q;
	logic                 led_level_q;
	logic                 blink_active_q;

	logic advance;

	// Next state and result
	logic [2:0]         frame_count_d;
	logic               store_char;
	logic [3:0]         blink_remaining_d;
	logic [15:0]        blink_elapsed_d;
	logic               led_phase_d;
	logic               led_pin_d;
	cfr_pkg::event_t    event_d;
	logic [3:0]         robot_index_d;
	logic [7:0]         robot_speed_d;
	logic [7:0]         robot_status_d;
	logic               clear_pickup_d;
	logic               clear_delivery_d;
	logic [7:0]         request_post_d;
	logic signed [12:0] request_dest_d;
	logic [1:0]         request_service_d;

	// Frame decode helpers
	cfr_pkg::char_t     c0, c1, c2, c3;
	logic               is_term;
	logic               is_null;
	logic [7:0]         robot_num;
	logic               robot_ok;
	logic               service_upper;
	logic               post_ok;
	logic               blink_letter;
	logic [7:0]         folded_c0;
	logic [2:0]         blink_n;
	logic signed [12:0] tens;
	logic signed [12:0] units;
	logic [15:0]        elapsed_inc;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign c0 = frame_chars_q[0];
	assign c1 = frame_chars_q[1];
	assign c2 = frame_chars_q[2];
	assign c3 = frame_chars_q[3];

	assign is_term  = (byte_s1 == cfr_pkg::CH_CR) || (byte_s1 == cfr_pkg::CH_LF);
	assign is_null  = (c0 == cfr_pkg::CH_N) && (c1 == cfr_pkg::CH_U)
		&& (c2 == cfr_pkg::CH_L) && (c3 == cfr_pkg::CH_L);
	assign robot_num = c1 - cfr_pkg::CH_ZERO;
	assign robot_ok = (c0 == cfr_pkg::CH_R) && ({24'd0, robot_num} < cfr_pkg::ROBOT_COUNT);
	assign service_upper = (c0 >= cfr_pkg::CH_A) && (c0 <= cfr_pkg::CH_D);
	assign post_ok  = ({24'd0, post_s1} < cfr_pkg::POST_COUNT);

	// Folding in the case bit maps both 'A'..'D' and 'a'..'d' onto 'a'..'d'.
	assign folded_c0    = c0 | cfr_pkg::CASE_BIT;
	assign blink_letter = (folded_c0 >= cfr_pkg::CH_LOW_A) && (folded_c0 <= cfr_pkg::CH_LOW_D);
	assign blink_n      = 3'(folded_c0 - cfr_pkg::CH_LOW_A) + 3'd1;

	assign tens  = (13'(signed'({5'd0, c2})) - 13'sd48) * 13'sd10;
	assign units = 13'(signed'({5'd0, c3})) - 13'sd48;

	assign elapsed_inc = (blink_elapsed_q < cfr_pkg::ELAPSED_MAX)
		? blink_elapsed_q + 16'd1 : blink_elapsed_q;

	always_comb begin
		frame_count_d     = frame_count_q;
		store_char        = 1'b0;
		blink_remaining_d = blink_remaining_q;
		blink_elapsed_d   = blink_elapsed_q;
		led_phase_d       = led_phase_q;
		led_pin_d         = led_pin_q;
		event_d           = cfr_pkg::EV_NONE;
		robot_index_d     = '0;
		robot_speed_d     = '0;
		robot_status_d    = '0;
		clear_pickup_d    = 1'b0;
		clear_delivery_d  = 1'b0;
		request_post_d    = '0;
		request_dest_d    = '0;
		request_service_d = '0;

		if (cmd_s1 == cfr_pkg::CMD_BYTE) begin
			if (is_term) begin
				frame_count_d = '0;
				if (frame_count_q == 3'(cfr_pkg::FRAME_LEN)) begin
					if (is_null) begin
						event_d = cfr_pkg::EV_NULL;
					end else begin
						event_d = cfr_pkg::EV_OTHER;
						if (robot_ok) begin
							event_d          = cfr_pkg::EV_ROBOT;
							robot_index_d    = robot_num[3:0];
							robot_speed_d    = c2;
							robot_status_d   = c3;
							clear_pickup_d   = (c3 == cfr_pkg::CH_E);
							clear_delivery_d = (c3 == cfr_pkg::CH_D);
						end else if (c0 != cfr_pkg::CH_R && service_upper
								&& c1 == cfr_pkg::CH_P && post_ok) begin
							event_d           = cfr_pkg::EV_REQUEST;
							request_post_d    = post_s1;
							request_dest_d    = tens + units;
							request_service_d = 2'(c0 - cfr_pkg::CH_A);
						end
						if (blink_letter) begin
							blink_remaining_d = {blink_n, 1'b0};
							blink_elapsed_d   = '0;
							led_phase_d       = 1'b0;
						end else begin
							blink_remaining_d = '0;
							led_pin_d         = 1'b1;
						end
					end
				end
			end else if (frame_count_q < 3'(cfr_pkg::FRAME_LEN)) begin
				store_char    = 1'b1;
				frame_count_d = frame_count_q + 3'd1;
			end else begin
				// A fifth character throws the whole frame away.
				frame_count_d = '0;
			end
		end else if (blink_remaining_q != '0) begin
			if (elapsed_inc >= blink_period_q) begin
				blink_elapsed_d   = '0;
				led_pin_d         = led_phase_q;
				led_phase_d       = !led_phase_q;
				blink_remaining_d = blink_remaining_q - 4'd1;
			end else begin
				blink_elapsed_d = elapsed_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			byte_s1 <= rx_byte;
			post_s1 <= post_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q    <= cfr_pkg::BLINK_PERIOD_RESET;
			frame_count_q     <= '0;
			blink_remaining_q <= '0;
			blink_elapsed_q   <= '0;
			led_phase_q       <= 1'b0;
			led_pin_q         <= 1'b1;
		end else begin
			if (cfg_we) begin
				blink_period_q <= cfg_wdata;
			end
			if (advance) begin
				frame_count_q     <= frame_count_d;
				blink_remaining_q <= blink_remaining_d;
				blink_elapsed_q   <= blink_elapsed_d;
				led_phase_q       <= led_phase_d;
				led_pin_q         <= led_pin_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store_char) begin
			frame_chars_q[frame_count_q[1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q           <= event_d;
			robot_index_q     <= robot_index_d;
			robot_speed_q     <= robot_speed_d;
			robot_status_q    <= robot_status_d;
			clear_pickup_q    <= clear_pickup_d;
			clear_delivery_q  <= clear_delivery_d;
			request_post_q    <= request_post_d;
			request_dest_q    <= request_dest_d;
			request_service_q <= request_service_d;
			led_level_q       <= led_pin_d;
			blink_active_q    <= (blink_remaining_d != '0);
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = event_q;
	assign robot_index     = robot_index_q;
	assign robot_speed     = robot_speed_q;
	assign robot_status    = robot_status_q;
	assign clear_pickup    = clear_pickup_q;
	assign clear_delivery  = clear_delivery_q;
	assign request_post    = request_post_q;
	assign request_dest    = request_dest_q;
	assign request_service = request_service_q;
	assign led_level       = led_level_q;
	assign blink_active    = blink_active_q;

endmodule

// File: tb/sv/command_frame_receiver_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_receiver_top_test
// Self-checking bench for the command frame receiver. A scoreboard keeps its
// own model of frame assembly, decoding and the LED blink. It predicts one
// result per accepted word and compares each result from the block field by
// field. Stimulus is a short directed list, then random well-formed frames,
// tick bursts and malformed input under several blink periods, with random
// stalls on both sides and two long output hold-offs.
// ----------------------------------------------------------------------------
module command_frame_receiver_top_test;

	localparam int unsigned IDLE_PCT        = 33;
	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES     = 150;
	localparam int unsigned WORDS_PER_PHASE = 225;

	typedef struct packed {
		cfr_pkg::event_t    ev;
		logic [3:0]         robot;
		cfr_pkg::char_t     speed;
		cfr_pkg::char_t     status;
		logic               pickup;
		logic               delivery;
		logic [7:0]         post;
		logic signed [12:0] dest;
		logic [1:0]         service;
		logic               led;
		logic               blinking;
	} frame_result_t;

	class frame_scoreboard;
		logic [15:0]    period;
		int unsigned    held;
		cfr_pkg::char_t chars[cfr_pkg::FRAME_LEN];
		logic [3:0]     toggles_left;
		logic [15:0]    elapsed;
		logic           phase;
		logic           led;
		frame_result_t  due_results[$];
		int unsigned    errors;
		int unsigned    checked;

		function void reset_state();
			period = cfr_pkg::BLINK_PERIOD_RESET;
			held = 0;
			foreach (chars[i])
				chars[i] = '0;
			toggles_left = '0;
			elapsed = '0;
			phase = 1'b0;
			led = 1'b1;
			errors = 0;
			checked = 0;
		endfunction

		function void set_period(logic [15:0] p);
			period = p;
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		// Decodes the four held characters and updates the blink state.
		function frame_result_t decode_frame(logic [7:0] post);
			frame_result_t  res;
			cfr_pkg::char_t offset;
			int             dest;
			int unsigned    n;
			res = '0;
			n = 0;
			if (chars[0] == cfr_pkg::CH_N && chars[1] == cfr_pkg::CH_U
					&& chars[2] == cfr_pkg::CH_L && chars[3] == cfr_pkg::CH_L) begin
				res.ev = cfr_pkg::EV_NULL;
				return res;
			end
			res.ev = cfr_pkg::EV_OTHER;
			if (chars[0] == cfr_pkg::CH_R) begin
				offset = chars[1] - cfr_pkg::CH_ZERO;
				if (offset < cfr_pkg::ROBOT_COUNT) begin
					res.ev = cfr_pkg::EV_ROBOT;
					res.robot = offset[3:0];
					res.speed = chars[2];
					res.status = chars[3];
					res.pickup = (chars[3] == cfr_pkg::CH_E);
					res.delivery = (chars[3] == cfr_pkg::CH_D);
				end
			end else if (chars[0] >= cfr_pkg::CH_A && chars[0] <= cfr_pkg::CH_D
					&& chars[1] == cfr_pkg::CH_P) begin
				if (post < cfr_pkg::POST_COUNT) begin
					dest = (int'(chars[2]) - int'(cfr_pkg::CH_ZERO)) * 10
						+ (int'(chars[3]) - int'(cfr_pkg::CH_ZERO));
					offset = chars[0] - cfr_pkg::CH_A;
					res.ev = cfr_pkg::EV_REQUEST;
					res.post = post;
					res.dest = dest[12:0];
					res.service = offset[1:0];
				end
			end
			if (chars[0] >= cfr_pkg::CH_A && chars[0] <= cfr_pkg::CH_D)
				n = int'(chars[0] - cfr_pkg::CH_A) + 1;
			else if (chars[0] >= cfr_pkg::CH_LOW_A && chars[0] <= cfr_pkg::CH_LOW_D)
				n = int'(chars[0] - cfr_pkg::CH_LOW_A) + 1;
			if (n != 0) begin
				toggles_left = 4'(2 * n);
				elapsed = '0;
				phase = 1'b0;
			end else begin
				toggles_left = '0;
				led = 1'b1;
			end
			return res;
		endfunction

		function void note_word(logic cmd, cfr_pkg::char_t b, logic [7:0] post);
			frame_result_t res;
			res = '0;
			if (cmd == cfr_pkg::CMD_TICK) begin
				if (toggles_left != 0) begin
					if (elapsed != cfr_pkg::ELAPSED_MAX)
						elapsed++;
					if (elapsed >= period) begin
						// Phase 0 drives the pin low, phase 1 drives it high.
						elapsed = '0;
						led = phase;
						phase = !phase;
						toggles_left--;
					end
				end
			end else if (b == cfr_pkg::CH_CR || b == cfr_pkg::CH_LF) begin
				if (held == cfr_pkg::FRAME_LEN)
					res = decode_frame(post);
				held = 0;
			end else if (held < cfr_pkg::FRAME_LEN) begin
				chars[held] = b;
				held++;
			end else begin
				held = 0;
			end
			res.led = led;
			res.blinking = (toggles_left != 0);
			due_results.push_back(res);
		endfunction

		function void compare_field(string name, int want, int seen);
			if (want != seen) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
				errors++;
			end
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			checked++;
			if (due_results.size() == 0) begin
				$display("%0t: event_res expected no result, got %0d", $time, got.ev);
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare_field("event_res", want.ev, got.ev);
			compare_field("robot_index", want.robot, got.robot);
			compare_field("robot_speed", want.speed, got.speed);
			compare_field("robot_status", want.status, got.status);
			compare_field("clear_pickup", want.pickup, got.pickup);
			compare_field("clear_delivery", want.delivery, got.delivery);
			compare_field("request_post", want.post, got.post);
			compare_field("request_dest", want.dest, got.dest);
			compare_field("request_service", want.service, got.service);
			compare_field("led_level", want.led, got.led);
			compare_field("blink_active", want.blinking, got.blinking);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [15:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               command = cfr_pkg::CMD_BYTE;
	logic [7:0]         rx_byte = '0;
	logic [7:0]         post_index = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         event_res;
	logic [3:0]         robot_index;
	logic [7:0]         robot_speed;
	logic [7:0]         robot_status;
	logic               clear_pickup;
	logic               clear_delivery;
	logic [7:0]         request_post;
	logic signed [12:0] request_dest;
	logic [1:0]         request_service;
	logic               led_level;
	logic               blink_active;

	frame_scoreboard sb = new();
	int unsigned     words_sent = 0;
	logic            no_idle = 1'b0;

	always #5ns clk = ~clk;

	command_frame_receiver_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.rx_byte         (rx_byte),
		.post_index      (post_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_res       (event_res),
		.robot_index     (robot_index),
		.robot_speed     (robot_speed),
		.robot_status    (robot_status),
		.clear_pickup    (clear_pickup),
		.clear_delivery  (clear_delivery),
		.request_post    (request_post),
		.request_dest    (request_dest),
		.request_service (request_service),
		.led_level       (led_level),
		.blink_active    (blink_active)
	);

	function automatic logic [7:0] rand_post();
		return ($urandom_range(3) != 0) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
	endfunction

	function automatic cfr_pkg::char_t pick_term();
		return $urandom_range(1) ? cfr_pkg::CH_CR : cfr_pkg::CH_LF;
	endfunction

	function automatic cfr_pkg::char_t digit_or_any();
		return ($urandom_range(4) != 0)
			? cfr_pkg::CH_ZERO + cfr_pkg::char_t'($urandom_range(9))
			: cfr_pkg::char_t'($urandom);
	endfunction

	task automatic send_word(input logic cmd, input cfr_pkg::char_t b,
			input logic [7:0] post);
		if (!no_idle) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		command <= cmd;
		rx_byte <= b;
		post_index <= post;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(cmd, b, post);
		words_sent++;
	endtask

	task automatic send_frame(input cfr_pkg::char_t c0, c1, c2, c3, term,
			input logic [7:0] post);
		send_word(cfr_pkg::CMD_BYTE, c0, rand_post());
		send_word(cfr_pkg::CMD_BYTE, c1, rand_post());
		send_word(cfr_pkg::CMD_BYTE, c2, rand_post());
		send_word(cfr_pkg::CMD_BYTE, c3, rand_post());
		send_word(cfr_pkg::CMD_BYTE, term, post);
	endtask

	task automatic write_period(input logic [15:0] p);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_period(p);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned    start;
		int unsigned    pick;
		cfr_pkg::char_t c0, c1, c2, c3;
		start = words_sent;
		while (words_sent - start < count) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				// Tick burst; the byte and post fields are don't-care here.
				repeat ($urandom_range(1, 12))
					send_word(cfr_pkg::CMD_TICK, cfr_pkg::char_t'($urandom), 8'($urandom));
			end else if (pick < 80) begin
				c0 = cfr_pkg::char_t'($urandom);
				c1 = cfr_pkg::char_t'($urandom);
				c2 = cfr_pkg::char_t'($urandom);
				c3 = cfr_pkg::char_t'($urandom);
				case ($urandom_range(9))
					0: begin
						c0 = cfr_pkg::CH_N;
						c1 = cfr_pkg::CH_U;
						c2 = cfr_pkg::CH_L;
						c3 = cfr_pkg::CH_L;
					end
					1, 2, 3: begin
						c0 = cfr_pkg::CH_R;
						c1 = digit_or_any();
						pick = $urandom_range(2);
						c3 = (pick == 0) ? cfr_pkg::CH_E : (pick == 1) ? cfr_pkg::CH_D : c3;
					end
					4, 5, 6: begin
						c0 = ($urandom_range(1) ? cfr_pkg::CH_A : cfr_pkg::CH_LOW_A)
							+ cfr_pkg::char_t'($urandom_range(3));
						c1 = ($urandom_range(4) != 0) ? cfr_pkg::CH_P : c1;
						c2 = digit_or_any();
						c3 = digit_or_any();
					end
					8: begin
						// Characters just outside both blink ranges.
						pick = $urandom_range(3);
						c0 = (pick == 0) ? cfr_pkg::CH_A - 8'd1
							: (pick == 1) ? cfr_pkg::CH_D + 8'd1
							: (pick == 2) ? cfr_pkg::CH_LOW_A - 8'd1
							: cfr_pkg::CH_LOW_D + 8'd1;
						c1 = cfr_pkg::CH_P;
						c2 = digit_or_any();
						c3 = digit_or_any();
					end
					9: begin
						c0 = cfr_pkg::CH_N;
						c1 = cfr_pkg::CH_U;
						c2 = cfr_pkg::CH_L;
					end
					default: ;
				endcase
				send_frame(c0, c1, c2, c3, pick_term(), rand_post());
			end else if (pick < 95) begin
				// Short or overlong frame, closed by a terminator.
				repeat ((pick < 90) ? $urandom_range(1, 3) : $urandom_range(5, 7))
					send_word(cfr_pkg::CMD_BYTE, cfr_pkg::char_t'($urandom), rand_post());
				send_word(cfr_pkg::CMD_BYTE, pick_term(), rand_post());
			end else begin
				send_word(1'($urandom), cfr_pkg::char_t'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		logic [15:0] periods[7];
		periods = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd3, 16'd1, 16'd150};
		periods[4] = 16'($urandom_range(3, 12));
		sb.reset_state();
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;

		// A terminator with nothing held does nothing.
		send_word(cfr_pkg::CMD_BYTE, cfr_pkg::CH_LF, 8'h00);
		send_frame(cfr_pkg::CH_N, cfr_pkg::CH_U, cfr_pkg::CH_L, cfr_pkg::CH_L,
			cfr_pkg::CH_CR, 8'hFF);
		send_frame(cfr_pkg::CH_R, cfr_pkg::CH_ZERO + 8'd7, 8'hFF, cfr_pkg::CH_E,
			cfr_pkg::CH_LF, 8'h00);
		send_frame(cfr_pkg::CH_D, cfr_pkg::CH_P, 8'h00, 8'h00, cfr_pkg::CH_CR,
			8'(cfr_pkg::POST_COUNT - 1));
		send_frame(cfr_pkg::CH_A, cfr_pkg::CH_P, 8'hFF, 8'hFF, cfr_pkg::CH_LF, 8'h00);
		send_word(cfr_pkg::CMD_BYTE, cfr_pkg::CH_LOW_A, 8'h00);
		send_word(cfr_pkg::CMD_BYTE, cfr_pkg::CH_LOW_A + 8'd1, 8'h00);
		send_word(cfr_pkg::CMD_BYTE, cfr_pkg::CH_CR, 8'h00);
		// The fifth character drops the frame, so the terminator finds nothing.
		send_word(cfr_pkg::CMD_BYTE, cfr_pkg::CH_R, 8'h00);
		send_word(cfr_pkg::CMD_BYTE, cfr_pkg::CH_ZERO, 8'h00);
		send_word(cfr_pkg::CMD_BYTE, cfr_pkg::CH_LOW_A, 8'h00);
		send_word(cfr_pkg::CMD_BYTE, cfr_pkg::CH_D, 8'h00);
		send_word(cfr_pkg::CMD_BYTE, cfr_pkg::CH_N, 8'h00);
		send_word(cfr_pkg::CMD_BYTE, cfr_pkg::CH_CR, 8'h00);

		run_random(WORDS_PER_PHASE);
		for (int i = 0; i < 7; i++) begin
			write_period(periods[i]);
			no_idle = (i == 2);
			run_random(WORDS_PER_PHASE);
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : result_sink
		frame_result_t got;
		int unsigned   hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.ev = cfr_pkg::event_t'(event_res);
				got.robot = robot_index;
				got.speed = robot_speed;
				got.status = robot_status;
				got.pickup = clear_pickup;
				got.delivery = clear_delivery;
				got.post = request_post;
				got.dest = request_dest;
				got.service = request_service;
				got.led = led_level;
				got.blinking = blink_active;
				sb.check_result(got);
				// Long hold-off so the block fills up and stalls its input.
				if (sb.checked == 200 || sb.checked == 1000)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin : watchdog
		int unsigned stall;
		stall = 0;
		while (stall < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall = 0;
			else
				stall++;
		end
		$display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
